// ----- hw/rtl/mnh_pkg.sv -----
// shared types and constants for the mouse nibble handshake port
`default_nettype none

package mnh_pkg;

  localparam int MOTION_WIDTH_DEF = 12;
  localparam int HELD_MAX         = 255;

  localparam int PHASE_W = 4;
  localparam int NIBBLE_W = 4;
  localparam int DATA_W  = 5;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE   = 4'd0;
  localparam logic [PHASE_W-1:0] PH_ID     = 4'd1;
  localparam logic [PHASE_W-1:0] PH_ID2    = 4'd2;
  localparam logic [PHASE_W-1:0] PH_ID3    = 4'd3;
  localparam logic [PHASE_W-1:0] PH_FLAGS  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_BTNS   = 4'd5;
  localparam logic [PHASE_W-1:0] PH_X_HI   = 4'd6;
  localparam logic [PHASE_W-1:0] PH_X_LO   = 4'd7;
  localparam logic [PHASE_W-1:0] PH_Y_HI   = 4'd8;
  localparam logic [PHASE_W-1:0] PH_LAST   = 4'd9;

  // fixed port answers
  localparam logic [DATA_W-1:0] PD_IDLE = 5'h10;
  localparam logic [DATA_W-1:0] PD_ID   = 5'h1B;
  localparam logic [DATA_W-1:0] PD_ID2  = 5'h0F;
  localparam logic [DATA_W-1:0] PD_ID3  = 5'h1F;
  localparam logic [DATA_W-1:0] PD_BUSY = 5'h10;

  typedef struct packed {
    logic                select_level;
    logic                strobe_level;
    logic [NIBBLE_W-1:0] buttons_n;
  } mnh_lines_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mnh_clamp.sv -----
// combinational saturating clamp of one motion axis to a byte with sign and overflow flags
`default_nettype none

module mnh_clamp #(
  parameter int MOTION_WIDTH = mnh_pkg::MOTION_WIDTH_DEF
) (
  input  wire logic signed [MOTION_WIDTH-1:0] motion,
  output logic             [7:0]              held,
  output logic                                sign,
  output logic                                over
);
  import mnh_pkg::*;

  localparam logic signed [MOTION_WIDTH-1:0] POS_LIM = MOTION_WIDTH'(HELD_MAX);
  localparam logic signed [MOTION_WIDTH-1:0] NEG_LIM = -POS_LIM;

  logic over_pos;
  logic over_neg;

  assign over_pos = motion > POS_LIM;
  assign over_neg = motion < NEG_LIM;
  assign sign     = motion[MOTION_WIDTH-1];
  assign over     = over_pos | over_neg;
  // in-range negatives keep their two's complement low byte
  assign held     = over ? 8'hFF : motion[7:0];

endmodule

`default_nettype wire

// ----- hw/rtl/mnh_in_stage.sv -----
// input register stage for line levels and motion
`default_nettype none

module mnh_in_stage #(
  parameter int MOTION_WIDTH = mnh_pkg::MOTION_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire mnh_pkg::mnh_lines_t              in_lines,
  input  wire logic signed [MOTION_WIDTH-1:0]   in_mx,
  input  wire logic signed [MOTION_WIDTH-1:0]   in_my,
  output logic                                  s1_valid,
  input  wire logic                             s1_take,
  output mnh_pkg::mnh_lines_t                   s1_lines,
  output logic signed [MOTION_WIDTH-1:0]        s1_mx,
  output logic signed [MOTION_WIDTH-1:0]        s1_my
);
  import mnh_pkg::*;

  logic                           valid_r;
  mnh_lines_t                     lines_r;
  logic signed [MOTION_WIDTH-1:0] mx_r;
  logic signed [MOTION_WIDTH-1:0] my_r;

  assign in_ready = !valid_r || s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      lines_r <= in_lines;
      mx_r    <= in_mx;
      my_r    <= in_my;
    end
  end

  assign s1_valid = valid_r;
  assign s1_lines = lines_r;
  assign s1_mx    = mx_r;
  assign s1_my    = my_r;

endmodule

`default_nettype wire

// ----- hw/rtl/mnh_engine.sv -----
// phase tracking, motion hold and result register
`default_nettype none

module mnh_engine #(
  parameter int MOTION_WIDTH = mnh_pkg::MOTION_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           s1_valid,
  output logic                                s1_take,
  input  wire mnh_pkg::mnh_lines_t            s1_lines,
  input  wire logic signed [MOTION_WIDTH-1:0] s1_mx,
  input  wire logic signed [MOTION_WIDTH-1:0] s1_my,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [mnh_pkg::DATA_W-1:0]          out_port_data,
  output logic                                out_motion_taken
);
  import mnh_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               prev_sel_r, prev_str_r;
  logic [7:0]         held_x_r, held_x_nxt;
  logic [7:0]         held_y_r, held_y_nxt;
  logic [3:0]         held_flags_r, held_flags_nxt;
  logic               taken_nxt;
  logic [DATA_W-1:0]  data_nxt;

  logic               out_valid_r;
  logic [DATA_W-1:0]  data_r;
  logic               taken_r;

  logic [7:0]         cx, cy;
  logic               sx, ox, sy, oy;

  mnh_clamp #(.MOTION_WIDTH(MOTION_WIDTH)) u_clamp_x (
    .motion (s1_mx),
    .held   (cx),
    .sign   (sx),
    .over   (ox)
  );

  mnh_clamp #(.MOTION_WIDTH(MOTION_WIDTH)) u_clamp_y (
    .motion (s1_my),
    .held   (cy),
    .sign   (sy),
    .over   (oy)
  );

  assign s1_take = s1_valid && (!out_valid_r || out_ready);

  always_comb begin
    phase_nxt      = phase_r;
    held_x_nxt     = held_x_r;
    held_y_nxt     = held_y_r;
    held_flags_nxt = held_flags_r;
    taken_nxt      = 1'b0;
    if (s1_lines.select_level) begin
      phase_nxt = PH_IDLE;
    end else if (phase_r == PH_IDLE) begin
      // falling select starts a read
      if (prev_sel_r) begin
        phase_nxt      = PH_ID;
        held_x_nxt     = cx;
        held_y_nxt     = cy;
        held_flags_nxt = {oy, ox, sy, sx};
        taken_nxt      = 1'b1;
      end
    end else if (prev_str_r != s1_lines.strobe_level) begin
      if (phase_r < PH_LAST) begin
        phase_nxt = phase_r + PHASE_W'(1);
      end
    end
  end

  always_comb begin
    unique case (phase_nxt)
      PH_IDLE:  data_nxt = PD_IDLE;
      PH_ID:    data_nxt = PD_ID;
      PH_ID2:   data_nxt = PD_ID2;
      PH_ID3:   data_nxt = PD_ID3;
      PH_FLAGS: data_nxt = {1'b0, held_flags_nxt};
      PH_BTNS:  data_nxt = PD_BUSY | {1'b0, ~s1_lines.buttons_n};
      PH_X_HI:  data_nxt = {1'b0, held_x_nxt[7:4]};
      PH_X_LO:  data_nxt = PD_BUSY | {1'b0, held_x_nxt[3:0]};
      PH_Y_HI:  data_nxt = {1'b0, held_y_nxt[7:4]};
      default:  data_nxt = PD_BUSY | {1'b0, held_y_nxt[3:0]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      prev_sel_r   <= 1'b1;
      prev_str_r   <= 1'b1;
      held_x_r     <= '0;
      held_y_r     <= '0;
      held_flags_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (s1_take) begin
        phase_r      <= phase_nxt;
        prev_sel_r   <= s1_lines.select_level;
        prev_str_r   <= s1_lines.strobe_level;
        held_x_r     <= held_x_nxt;
        held_y_r     <= held_y_nxt;
        held_flags_r <= held_flags_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      data_r  <= data_nxt;
      taken_r <= taken_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_port_data    = data_r;
  assign out_motion_taken = taken_r;

endmodule

`default_nettype wire

// ----- hw/rtl/mouse_nibble_handshake_port.sv -----
// an accepted input beat passes through the input register and then the result register
// throughput: one beat per cycle while out_ready stays high, set by the input and result registers
// each holding one beat with ready passed back combinationally
// reset: synchronous active-low; phase 0, select/strobe history high,
// held motion and flags zero, both register stages empty
`default_nettype none

module mouse_nibble_handshake_port #(
  parameter int MOTION_WIDTH = mnh_pkg::MOTION_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_select_level,
  input  wire logic                             in_strobe_level,
  input  wire logic [mnh_pkg::NIBBLE_W-1:0]     in_buttons_n,
  input  wire logic signed [MOTION_WIDTH-1:0]   in_motion_x,
  input  wire logic signed [MOTION_WIDTH-1:0]   in_motion_y,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [mnh_pkg::DATA_W-1:0]            out_port_data,
  output logic                                  out_motion_taken
);
  import mnh_pkg::*;

  mnh_lines_t                     in_lines;
  mnh_lines_t                     s1_lines;
  logic                           s1_valid;
  logic                           s1_take;
  logic signed [MOTION_WIDTH-1:0] s1_mx;
  logic signed [MOTION_WIDTH-1:0] s1_my;

  assign in_lines = '{select_level: in_select_level,
                      strobe_level: in_strobe_level,
                      buttons_n:    in_buttons_n};

  mnh_in_stage #(.MOTION_WIDTH(MOTION_WIDTH)) u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_lines (in_lines),
    .in_mx    (in_motion_x),
    .in_my    (in_motion_y),
    .s1_valid (s1_valid),
    .s1_take  (s1_take),
    .s1_lines (s1_lines),
    .s1_mx    (s1_mx),
    .s1_my    (s1_my)
  );

  mnh_engine #(.MOTION_WIDTH(MOTION_WIDTH)) u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .s1_valid         (s1_valid),
    .s1_take          (s1_take),
    .s1_lines         (s1_lines),
    .s1_mx            (s1_mx),
    .s1_my            (s1_my),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_port_data    (out_port_data),
    .out_motion_taken (out_motion_taken)
  );

`ifndef SYNTHESIS
  // a latch beat always answers with the id nibble
  a_taken_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_motion_taken |-> out_port_data == PD_ID)
    else $error("motion latch beat without id answer");

  // input stalls only when both stages are full and the result is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with room downstream");

  // a pending result that is not taken stays pending
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");
`endif

endmodule

`default_nettype wire
